// ===== rtl/igcl_pkg.sv =====
// Package for the gimbal control law block: payload types, widths, trig table and helpers.
`default_nettype none

package igcl_pkg;

   localparam int TRIG_DEPTH = 1024;
   localparam int TRIG_BITS  = $clog2(TRIG_DEPTH);
   localparam int TRIG_QTR   = TRIG_DEPTH / 4;
   localparam int QTR_BITS   = TRIG_BITS - 1;

   localparam int QUOT_BITS = 40;
   localparam int DIV_W     = 128;

   localparam logic [1:0]  CSR_MASS   = 2'd0;
   localparam logic [1:0]  CSR_KF     = 2'd1;
   localparam logic [31:0] MASS_RESET = 32'd65536;
   localparam logic [31:0] KF_RESET   = 32'd65536;

   localparam logic signed [46:0] TRIG_HALF = 47'sd1 <<< (44 - TRIG_BITS);
   localparam logic [63:0] TAYLOR_DIV [0:5] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

   typedef struct packed {
      logic signed [15:0] roll_angle;
      logic signed [15:0] pitch_angle;
      logic signed [15:0] yaw_angle;
      logic signed [15:0] gimbal_angle_a;
      logic signed [15:0] gimbal_angle_b;
      logic signed [23:0] rotor_speed;
      logic signed [23:0] error_x;
      logic signed [23:0] error_y;
      logic signed [23:0] error_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] command_x;
      logic signed [31:0] command_y;
      logic signed [31:0] command_z;
      logic               singular_flag;
   } rsp_type;

   typedef logic signed [25:0] q24_type;
   typedef logic signed [26:0] rel_type;
   typedef logic signed [27:0] bel_type;
   typedef logic signed [32:0] cof_type;

   typedef struct packed {
      logic               singular;
      logic               neg;
      logic signed [31:0] base;
   } div_aux_type;

   typedef logic [24:0] sin_lut_type [0:TRIG_QTR];

   function automatic sin_lut_type build_sin_lut();
      sin_lut_type lut;
      logic [63:0] f;
      logic [63:0] r;
      logic [63:0] r2;
      logic [63:0] p;
      for (int fi = 0; fi <= TRIG_QTR; fi++) begin
         f  = 64'(fi) << (32 - TRIG_BITS);
         r  = (f * 64'd1686629713 + (64'd1 << 29)) >> 30;
         r2 = (r * r + (64'd1 << 29)) >> 30;
         p  = 64'd1 << 30;
         for (int i = 0; i < 6; i++) begin
            p = (64'd1 << 30) - (((r2 * p + (64'd1 << 29)) >> 30) / TAYLOR_DIV[i]);
         end
         lut[fi] = 25'((r * p + (64'd1 << 35)) >> 36);
      end
      return lut;
   endfunction

   localparam sin_lut_type SIN_LUT = build_sin_lut();

   function automatic logic [TRIG_BITS-1:0] trig_index(input logic signed [15:0] angle);
      logic signed [46:0] y;
      y = 47'(angle) * 47'sd683565276 + TRIG_HALF;
      return y[44 -: TRIG_BITS];
   endfunction

   function automatic q24_type sin_of(input logic [TRIG_BITS-1:0] k);
      logic [QTR_BITS-1:0] fi;
      logic [QTR_BITS-1:0] idx;
      logic [24:0]         mg;
      fi  = QTR_BITS'(k[TRIG_BITS-3:0]);
      idx = k[TRIG_BITS-2] ? QTR_BITS'(TRIG_QTR) - fi : fi;
      mg  = SIN_LUT[idx];
      return k[TRIG_BITS-1] ? -q24_type'(mg) : q24_type'(mg);
   endfunction

   function automatic logic signed [63:0] rnd24(input logic signed [63:0] x);
      logic [63:0] m;
      logic [63:0] r;
      m = x[63] ? 64'(-x) : 64'(x);
      r = (m + 64'd8388608) >> 24;
      return x[63] ? -$signed(r) : $signed(r);
   endfunction

   function automatic q24_type mulq(input q24_type a, input q24_type b);
      return q24_type'(rnd24(64'(a) * 64'(b)));
   endfunction

endpackage

`default_nettype wire

// ===== rtl/igcl_div.sv =====
// Pipelined restoring divider with a quotient capped at two to the fortieth, one bit per stage.
`default_nettype none

module igcl_div (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   input  wire logic [igcl_pkg::DIV_W-1:0]        num,
   input  wire logic [igcl_pkg::DIV_W-1:0]        den,
   input  wire igcl_pkg::div_aux_type             aux_in,
   output logic                                   out_valid,
   output logic [igcl_pkg::QUOT_BITS:0]           quot,
   output igcl_pkg::div_aux_type                  aux_out
);

   localparam int DW = igcl_pkg::DIV_W;
   localparam int QB = igcl_pkg::QUOT_BITS;
   localparam int EW = DW + QB;

   logic [QB:0]           v_ff;
   logic [DW-1:0]         rem_ff  [0:QB-1];
   logic [DW-1:0]         den_ff  [0:QB-1];
   logic [QB-1:0]         q_ff    [0:QB];
   logic [QB:0]           over_ff;
   igcl_pkg::div_aux_type aux_ff  [0:QB];

   logic                  ge_in   [1:QB];
   logic [DW-1:0]         diff_in [1:QB];

   always_comb begin
      logic [EW-1:0] dsh;
      logic [EW-1:0] rx;
      for (int s = 1; s <= QB; s++) begin
         dsh        = {{QB{1'b0}}, den_ff[s-1]} << (QB - s);
         rx         = {{QB{1'b0}}, rem_ff[s-1]};
         ge_in[s]   = rx >= dsh;
         diff_in[s] = DW'(rx - dsh);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[QB-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= num;
      den_ff[0]  <= den;
      q_ff[0]    <= '0;
      over_ff[0] <= {{QB{1'b0}}, num} >= {den, {QB{1'b0}}};
      aux_ff[0]  <= aux_in;
      for (int s = 1; s <= QB; s++) begin
         q_ff[s]    <= {q_ff[s-1][QB-2:0], ge_in[s]};
         over_ff[s] <= over_ff[s-1];
         aux_ff[s]  <= aux_ff[s-1];
      end
      for (int s = 1; s < QB; s++) begin
         rem_ff[s] <= ge_in[s] ? diff_in[s] : rem_ff[s-1];
         den_ff[s] <= den_ff[s-1];
      end
   end

   assign out_valid = v_ff[QB];
   assign quot      = over_ff[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, q_ff[QB]};
   assign aux_out   = aux_ff[QB];

endmodule

`default_nettype wire

// ===== rtl/indi_gimbal_control_law_top.sv =====
// Top level of the gimbal control law: trig, effectiveness matrix, inversion and command output.
//
//   channel   ports                                   beat
//   request   start, busy, req_data                   one sample
//   response  rsp_strobe, rsp_data                    commands and singular flag
//   csr       csr_we, csr_index, csr_wdata            one register write
//
// A sample is taken every cycle; busy stays low. The result passes through 16 datapath
// stages, 41 stages of the capped divider and one output register.
// The divider's one quotient bit per stage sets the depth.
// Reset clears every valid bit and loads the mass and thrust coefficient reset values.
// The receiver takes every beat, so nothing in the pipeline ever holds.
`default_nettype none

module indi_gimbal_control_law_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire igcl_pkg::req_type req_data,
   output logic                   rsp_strobe,
   output igcl_pkg::rsp_type      rsp_data,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_index,
   input  wire logic [31:0]       csr_wdata
);

   localparam int AX_R = 0;
   localparam int AX_P = 1;
   localparam int AX_Y = 2;
   localparam int AX_A = 3;
   localparam int AX_B = 4;
   localparam int NPIPE = 16;

   typedef struct packed {
      logic signed [31:0] base0;
      logic signed [31:0] base1;
      logic signed [31:0] base2;
      logic signed [23:0] w;
      logic signed [23:0] e0;
      logic signed [23:0] e1;
      logic signed [23:0] e2;
   } side_type;

   typedef logic signed [53:0] pr_type;
   typedef logic signed [56:0] cp_type;

   logic [31:0] mass_ff;
   logic [31:0] kf_ff;

   logic [NPIPE:1] v_ff;
   side_type       side_ff [1:NPIPE];
   side_type       side_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mass_ff <= igcl_pkg::MASS_RESET;
         kf_ff   <= igcl_pkg::KF_RESET;
      end else if (csr_we) begin
         case (csr_index)
            igcl_pkg::CSR_MASS: mass_ff <= csr_wdata;
            igcl_pkg::CSR_KF:   kf_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   always_comb begin
      side_in.base0 = 32'(req_data.roll_angle) * 32'sd8;
      side_in.base1 = 32'(req_data.pitch_angle) * 32'sd8;
      side_in.base2 = 32'(req_data.rotor_speed) * 32'sd256;
      side_in.w     = req_data.rotor_speed;
      side_in.e0    = req_data.error_x;
      side_in.e1    = req_data.error_y;
      side_in.e2    = req_data.error_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[NPIPE-1:1], start & ~busy};
      end
   end

   always_ff @(posedge clock) begin
      side_ff[1] <= side_in;
      for (int n = 2; n <= NPIPE; n++) begin
         side_ff[n] <= side_ff[n-1];
      end
   end

   // Phase indices, then sine and cosine from the quarter-wave table.
   logic signed [15:0]             ang [0:4];
   logic [igcl_pkg::TRIG_BITS-1:0] k1_ff [0:4];
   igcl_pkg::q24_type              sn2_ff [0:4];
   igcl_pkg::q24_type              cs2_ff [0:4];

   assign ang[AX_R] = req_data.roll_angle;
   assign ang[AX_P] = req_data.pitch_angle;
   assign ang[AX_Y] = req_data.yaw_angle;
   assign ang[AX_A] = req_data.gimbal_angle_a;
   assign ang[AX_B] = req_data.gimbal_angle_b;

   always_ff @(posedge clock) begin
      for (int j = 0; j < 5; j++) begin
         k1_ff[j]  <= igcl_pkg::trig_index(ang[j]);
         sn2_ff[j] <= igcl_pkg::sin_of(k1_ff[j]);
         cs2_ff[j] <= igcl_pkg::sin_of(k1_ff[j] +
                      igcl_pkg::TRIG_BITS'(igcl_pkg::TRIG_QTR));
      end
   end

   igcl_pkg::q24_type sr, cr, sp, cp, sy, cy, sa, ca, sb, cb;
   assign sr = sn2_ff[AX_R];
   assign cr = cs2_ff[AX_R];
   assign sp = sn2_ff[AX_P];
   assign cp = cs2_ff[AX_P];
   assign sy = sn2_ff[AX_Y];
   assign cy = cs2_ff[AX_Y];
   assign sa = sn2_ff[AX_A];
   assign ca = cs2_ff[AX_A];
   assign sb = sn2_ff[AX_B];
   assign cb = cs2_ff[AX_B];

   // First level of products.
   igcl_pkg::q24_type sacb3_ff, cacb3_ff, spsr3_ff, spcr3_ff, cpsr3_ff, cpcr3_ff;
   igcl_pkg::q24_type cycp3_ff, sycp3_ff, cysp3_ff, sysp3_ff;
   igcl_pkg::q24_type sycr3_ff, cycr3_ff, sysr3_ff, cysr3_ff;
   igcl_pkg::q24_type sp3_ff, cp3_ff, sy3_ff, cy3_ff, sb3_ff;

   always_ff @(posedge clock) begin
      sacb3_ff <= igcl_pkg::mulq(sa, cb);
      cacb3_ff <= igcl_pkg::mulq(ca, cb);
      spsr3_ff <= igcl_pkg::mulq(sp, sr);
      spcr3_ff <= igcl_pkg::mulq(sp, cr);
      cpsr3_ff <= igcl_pkg::mulq(cp, sr);
      cpcr3_ff <= igcl_pkg::mulq(cp, cr);
      cycp3_ff <= igcl_pkg::mulq(cy, cp);
      sycp3_ff <= igcl_pkg::mulq(sy, cp);
      cysp3_ff <= igcl_pkg::mulq(cy, sp);
      sysp3_ff <= igcl_pkg::mulq(sy, sp);
      sycr3_ff <= igcl_pkg::mulq(sy, cr);
      cycr3_ff <= igcl_pkg::mulq(cy, cr);
      sysr3_ff <= igcl_pkg::mulq(sy, sr);
      cysr3_ff <= igcl_pkg::mulq(cy, sr);
      sp3_ff   <= sp;
      cp3_ff   <= cp;
      sy3_ff   <= sy;
      cy3_ff   <= cy;
      sb3_ff   <= sb;
   end

   // Second level of products.
   igcl_pkg::q24_type cyspsr4_ff, cyspcr4_ff, syspsr4_ff, syspcr4_ff;
   igcl_pkg::q24_type cycpsr4_ff, cycpcr4_ff, sycpsr4_ff, sycpcr4_ff;
   igcl_pkg::q24_type cycp4_ff, sycp4_ff, sycr4_ff, cycr4_ff, sysr4_ff, cysr4_ff;
   igcl_pkg::q24_type spsr4_ff, spcr4_ff, cpsr4_ff, cpcr4_ff, sp4_ff, cp4_ff;
   igcl_pkg::q24_type cysp4_ff, sysp4_ff, g04_ff, g14_ff, g24_ff;

   always_ff @(posedge clock) begin
      cyspsr4_ff <= igcl_pkg::mulq(cy3_ff, spsr3_ff);
      cyspcr4_ff <= igcl_pkg::mulq(cy3_ff, spcr3_ff);
      syspsr4_ff <= igcl_pkg::mulq(sy3_ff, spsr3_ff);
      syspcr4_ff <= igcl_pkg::mulq(sy3_ff, spcr3_ff);
      cycpsr4_ff <= igcl_pkg::mulq(cy3_ff, cpsr3_ff);
      cycpcr4_ff <= igcl_pkg::mulq(cy3_ff, cpcr3_ff);
      sycpsr4_ff <= igcl_pkg::mulq(sy3_ff, cpsr3_ff);
      sycpcr4_ff <= igcl_pkg::mulq(sy3_ff, cpcr3_ff);
      cycp4_ff   <= cycp3_ff;
      sycp4_ff   <= sycp3_ff;
      sycr4_ff   <= sycr3_ff;
      cycr4_ff   <= cycr3_ff;
      sysr4_ff   <= sysr3_ff;
      cysr4_ff   <= cysr3_ff;
      spsr4_ff   <= spsr3_ff;
      spcr4_ff   <= spcr3_ff;
      cpsr4_ff   <= cpsr3_ff;
      cpcr4_ff   <= cpcr3_ff;
      sp4_ff     <= sp3_ff;
      cp4_ff     <= cp3_ff;
      cysp4_ff   <= cysp3_ff;
      sysp4_ff   <= sysp3_ff;
      g04_ff     <= sb3_ff;
      g14_ff     <= -sacb3_ff;
      g24_ff     <= cacb3_ff;
   end

   // Rotation matrix, its pitch derivative and the thrust direction.
   igcl_pkg::rel_type r5_ff [0:2][0:2];
   igcl_pkg::rel_type t5_ff [0:2][0:2];
   igcl_pkg::q24_type g5_ff [0:2];

   always_ff @(posedge clock) begin
      r5_ff[0][0] <= igcl_pkg::rel_type'(cycp4_ff);
      r5_ff[0][1] <= igcl_pkg::rel_type'(cyspsr4_ff) - igcl_pkg::rel_type'(sycr4_ff);
      r5_ff[0][2] <= igcl_pkg::rel_type'(sysr4_ff) + igcl_pkg::rel_type'(cyspcr4_ff);
      r5_ff[1][0] <= igcl_pkg::rel_type'(sycp4_ff);
      r5_ff[1][1] <= igcl_pkg::rel_type'(cycr4_ff) + igcl_pkg::rel_type'(syspsr4_ff);
      r5_ff[1][2] <= igcl_pkg::rel_type'(syspcr4_ff) - igcl_pkg::rel_type'(cysr4_ff);
      r5_ff[2][0] <= -igcl_pkg::rel_type'(sp4_ff);
      r5_ff[2][1] <= igcl_pkg::rel_type'(cpsr4_ff);
      r5_ff[2][2] <= igcl_pkg::rel_type'(cpcr4_ff);
      t5_ff[0][0] <= -igcl_pkg::rel_type'(cysp4_ff);
      t5_ff[0][1] <= igcl_pkg::rel_type'(cycpsr4_ff);
      t5_ff[0][2] <= igcl_pkg::rel_type'(cycpcr4_ff);
      t5_ff[1][0] <= -igcl_pkg::rel_type'(sysp4_ff);
      t5_ff[1][1] <= igcl_pkg::rel_type'(sycpsr4_ff);
      t5_ff[1][2] <= igcl_pkg::rel_type'(sycpcr4_ff);
      t5_ff[2][0] <= -igcl_pkg::rel_type'(cp4_ff);
      t5_ff[2][1] <= -igcl_pkg::rel_type'(spsr4_ff);
      t5_ff[2][2] <= -igcl_pkg::rel_type'(spcr4_ff);
      g5_ff[0]    <= g04_ff;
      g5_ff[1]    <= g14_ff;
      g5_ff[2]    <= g24_ff;
   end

   // Matrix columns times the thrust direction, then the rounded sums.
   pr_type            pr6_in [0:2][0:2][0:2];
   pr_type            pr6_ff [0:2][0:2][0:2];
   igcl_pkg::bel_type b7_ff  [0:2][0:2];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pr6_in[i][0][0] = '0;
         pr6_in[i][0][1] = pr_type'(64'(r5_ff[i][2]) * 64'(g5_ff[1]));
         pr6_in[i][0][2] = pr_type'(-(64'(r5_ff[i][1]) * 64'(g5_ff[2])));
         for (int k = 0; k < 3; k++) begin
            pr6_in[i][1][k] = pr_type'(64'(t5_ff[i][k]) * 64'(g5_ff[k]));
            pr6_in[i][2][k] = pr_type'(64'(r5_ff[i][k]) * 64'(g5_ff[k]));
         end
      end
   end

   always_ff @(posedge clock) begin
      pr6_ff <= pr6_in;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            b7_ff[i][j] <= igcl_pkg::bel_type'(igcl_pkg::rnd24(64'(pr6_ff[i][j][0]) +
                           64'(pr6_ff[i][j][1]) + 64'(pr6_ff[i][j][2])));
         end
      end
   end

   // Cofactors.
   cp_type            ca8_in [0:2][0:2];
   cp_type            cb8_in [0:2][0:2];
   cp_type            ca8_ff [0:2][0:2];
   cp_type            cb8_ff [0:2][0:2];
   igcl_pkg::bel_type brow8_ff [0:2];
   igcl_pkg::bel_type brow9_ff [0:2];
   igcl_pkg::cof_type c9_ff [0:2][0:2];

   always_comb begin
      int i1, i2, j1, j2;
      for (int i = 0; i < 3; i++) begin
         i1 = (i + 1 > 2) ? i - 2 : i + 1;
         i2 = (i + 2 > 2) ? i - 1 : i + 2;
         for (int j = 0; j < 3; j++) begin
            j1 = (j + 1 > 2) ? j - 2 : j + 1;
            j2 = (j + 2 > 2) ? j - 1 : j + 2;
            ca8_in[i][j] = cp_type'(64'(b7_ff[i1][j1]) * 64'(b7_ff[i2][j2]));
            cb8_in[i][j] = cp_type'(64'(b7_ff[i1][j2]) * 64'(b7_ff[i2][j1]));
         end
      end
   end

   always_ff @(posedge clock) begin
      ca8_ff <= ca8_in;
      cb8_ff <= cb8_in;
      for (int j = 0; j < 3; j++) begin
         brow8_ff[j] <= b7_ff[0][j];
         brow9_ff[j] <= brow8_ff[j];
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            c9_ff[i][j] <= igcl_pkg::cof_type'(igcl_pkg::rnd24(64'(ca8_ff[i][j]) -
                           64'(cb8_ff[i][j])));
         end
      end
   end

   // Determinant and adjugate times error.
   logic signed [23:0] e9 [0:2];
   logic signed [61:0] dp10_ff [0:2];
   logic signed [57:0] yp10_ff [0:2][0:2];
   logic signed [63:0] det11_ff;
   logic signed [59:0] y11_ff [0:2];

   assign e9[0] = side_ff[9].e0;
   assign e9[1] = side_ff[9].e1;
   assign e9[2] = side_ff[9].e2;

   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         dp10_ff[j] <= 62'(64'(brow9_ff[j]) * 64'(c9_ff[0][j]));
         for (int k = 0; k < 3; k++) begin
            yp10_ff[j][k] <= 58'(64'(c9_ff[k][j]) * 64'(e9[k]));
         end
      end
      det11_ff <= 64'(dp10_ff[0]) + 64'(dp10_ff[1]) + 64'(dp10_ff[2]);
      for (int i = 0; i < 3; i++) begin
         y11_ff[i] <= 60'(yp10_ff[i][0]) + 60'(yp10_ff[i][1]) + 60'(yp10_ff[i][2]);
      end
   end

   // Magnitudes, signs and the singular test.
   logic signed [23:0] w11;
   logic [58:0]        ym12_ff [0:2];
   logic [62:0]        dm12_ff;
   logic [2:0]         neg12_ff;
   logic [23:0]        wm12_ff;
   logic               sing12_ff;

   assign w11 = side_ff[11].w;

   always_ff @(posedge clock) begin
      sing12_ff <= (kf_ff == '0) || (w11 == '0) || (det11_ff == '0);
      dm12_ff   <= det11_ff[63] ? 63'(-det11_ff) : 63'(det11_ff);
      wm12_ff   <= w11[23] ? 24'(-w11) : 24'(w11);
      for (int i = 0; i < 3; i++) begin
         ym12_ff[i]  <= y11_ff[i][59] ? 59'(-y11_ff[i]) : 59'(y11_ff[i]);
         neg12_ff[i] <= y11_ff[i][59] ^ det11_ff[63] ^ ((i < 2) ? w11[23] : 1'b0);
      end
   end

   // Wide numerator and denominator products, built from 32-bit partial products.
   logic [63:0]  nl13_ff [0:2];
   logic [63:0]  nh13_ff [0:2];
   logic [63:0]  dl13_ff;
   logic [63:0]  dh13_ff;
   logic [23:0]  wm13_ff, wm14_ff;
   logic [2:0]   neg13_ff, neg14_ff, neg15_ff, neg16_ff;
   logic         sing13_ff, sing14_ff, sing15_ff, sing16_ff;
   logic [95:0]  num14_ff [0:2];
   logic [95:0]  num15_ff [0:2];
   logic [95:0]  num16_ff [0:2];
   logic [95:0]  den14_ff, den15_ff, den16a_ff;
   logic [63:0]  dp15_ff [0:2];
   logic [127:0] den16_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         nl13_ff[i]  <= 64'(ym12_ff[i][31:0]) * 64'(mass_ff);
         nh13_ff[i]  <= 64'(ym12_ff[i][58:32]) * 64'(mass_ff);
         num14_ff[i] <= 96'(nl13_ff[i]) + (96'(nh13_ff[i]) << 32);
         num15_ff[i] <= num14_ff[i];
         num16_ff[i] <= num15_ff[i];
         dp15_ff[i]  <= 64'(den14_ff[32*i +: 32]) * 64'(wm14_ff);
      end
      dl13_ff   <= 64'(dm12_ff[31:0]) * 64'(kf_ff);
      dh13_ff   <= 64'(dm12_ff[62:32]) * 64'(kf_ff);
      den14_ff  <= 96'(dl13_ff) + (96'(dh13_ff) << 32);
      den15_ff  <= den14_ff;
      den16a_ff <= den15_ff;
      den16_ff  <= 128'(dp15_ff[0]) + (128'(dp15_ff[1]) << 32) + (128'(dp15_ff[2]) << 64);
      wm13_ff   <= wm12_ff;
      wm14_ff   <= wm13_ff;
      neg13_ff  <= neg12_ff;
      neg14_ff  <= neg13_ff;
      neg15_ff  <= neg14_ff;
      neg16_ff  <= neg15_ff;
      sing13_ff <= sing12_ff;
      sing14_ff <= sing13_ff;
      sing15_ff <= sing14_ff;
      sing16_ff <= sing15_ff;
   end

   // Three capped dividers, one per command.
   logic signed [31:0]            base16 [0:2];
   logic [igcl_pkg::DIV_W-1:0]    dnum [0:2];
   logic [igcl_pkg::DIV_W-1:0]    dden [0:2];
   igcl_pkg::div_aux_type         daux [0:2];
   logic                          qv [0:2];
   logic [igcl_pkg::QUOT_BITS:0]  quot [0:2];
   igcl_pkg::div_aux_type         qaux [0:2];

   assign base16[0] = side_ff[NPIPE].base0;
   assign base16[1] = side_ff[NPIPE].base1;
   assign base16[2] = side_ff[NPIPE].base2;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         daux[i].singular = sing16_ff;
         daux[i].neg      = neg16_ff[i];
         daux[i].base     = base16[i];
      end
      dnum[0] = {num16_ff[0], 32'b0};
      dnum[1] = {num16_ff[1], 32'b0};
      dnum[2] = igcl_pkg::DIV_W'({num16_ff[2], 24'b0});
      dden[0] = den16_ff;
      dden[1] = den16_ff;
      dden[2] = igcl_pkg::DIV_W'(den16a_ff);
   end

   for (genvar gi = 0; gi < 3; gi++) begin : g_lane
      igcl_div u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (v_ff[NPIPE]),
         .num       (dnum[gi]),
         .den       (dden[gi]),
         .aux_in    (daux[gi]),
         .out_valid (qv[gi]),
         .quot      (quot[gi]),
         .aux_out   (qaux[gi])
      );
   end

   // Sum with the base vector and saturate; a singular sample passes the base vector through.
   logic signed [31:0] cmd_in [0:2];
   logic               rsp_strobe_ff;
   igcl_pkg::rsp_type  rsp_data_ff;
   igcl_pkg::rsp_type  rsp_data_in;

   always_comb begin
      logic signed [41:0] sum;
      for (int i = 0; i < 3; i++) begin
         sum = 42'(qaux[i].base) + (qaux[i].neg ? -42'(quot[i]) : 42'(quot[i]));
         if (qaux[i].singular) begin
            cmd_in[i] = qaux[i].base;
         end else if (sum > 42'sd2147483647) begin
            cmd_in[i] = 32'sh7fffffff;
         end else if (sum < -42'sd2147483648) begin
            cmd_in[i] = 32'sh80000000;
         end else begin
            cmd_in[i] = 32'(sum);
         end
      end
      rsp_data_in.command_x     = cmd_in[0];
      rsp_data_in.command_y     = cmd_in[1];
      rsp_data_in.command_z     = cmd_in[2];
      rsp_data_in.singular_flag = qaux[0].singular;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= qv[0] & qv[1] & qv[2];
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

`default_nettype wire

// ===== sim/indi_gimbal_control_law_top_test.sv =====
// Testbench for the gimbal control law block: directed and random samples checked by a scoreboard.
`timescale 1ns / 1ps

module indi_gimbal_control_law_top_test;
   import igcl_pkg::*;

   class command_scoreboard;
      logic [31:0] mass;
      logic [31:0] kf;
      rsp_type     awaited[$];
      int          failures;

      function new();
         mass     = MASS_RESET;
         kf       = KF_RESET;
         failures = 0;
      endfunction

      function longint round_shift(longint x, int s);
         logic [63:0] m;
         logic [63:0] r;
         m = x < 0 ? 64'(-x) : 64'(x);
         r = (m + (64'd1 << (s - 1))) >> s;
         return x < 0 ? -longint'(r) : longint'(r);
      endfunction

      function longint qmul(longint a, longint b);
         return round_shift(a * b, 24);
      endfunction

      function longint sine_of_turn(logic [31:0] t);
         logic [63:0] f;
         logic [63:0] r;
         logic [63:0] r2;
         logic [63:0] p;
         logic [63:0] dv[6];
         dv = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
         f = 64'(t[29:0]);
         if (t[30]) f = (64'd1 << 30) - f;
         r  = (f * 64'd1686629713 + (64'd1 << 29)) >> 30;
         r2 = (r * r + (64'd1 << 29)) >> 30;
         p  = 64'd1 << 30;
         for (int i = 0; i < 6; i++) p = (64'd1 << 30) - ((r2 * p + (64'd1 << 29)) >> 30) / dv[i];
         r = (r * p + (64'd1 << 35)) >> 36;
         return t[31] ? -longint'(r) : longint'(r);
      endfunction

      function void sin_cos(logic signed [15:0] ang, output longint sn, output longint cs);
         longint      x;
         logic [63:0] u;
         logic [31:0] t;
         x  = longint'(ang) * 64'sd683565276 * 64'sd1024;
         u  = 64'(x) + (64'd1024 << 45) + (64'd1 << 44);
         t  = 32'((u >> 45) % 64'd1024) << 22;
         sn = sine_of_turn(t);
         cs = sine_of_turn(t + 32'h4000_0000);
      endfunction

      function logic signed [31:0] clamp32(longint v);
         if (v > 64'sd2147483647) v = 64'sd2147483647;
         if (v < -64'sd2147483648) v = -64'sd2147483648;
         return v[31:0];
      endfunction

      function rsp_type command_law(req_type s);
         rsp_type      o;
         longint       w, sr, cr, sp, cp, sy, cy, sa, ca, sb, cb;
         longint       spsr, spcr, cpsr, cpcr, det, y, corr;
         longint       g[3], e[3], base[3];
         longint       rm[3][3], pm[3][3], tm[3][3], bm[3][3], cf[3][3];
         logic [127:0] num, den, q;
         logic         neg;
         w = s.rotor_speed;
         e = '{longint'(s.error_x), longint'(s.error_y), longint'(s.error_z)};
         base = '{longint'(s.roll_angle) * 8, longint'(s.pitch_angle) * 8, w * 256};
         sin_cos(s.roll_angle, sr, cr);
         sin_cos(s.pitch_angle, sp, cp);
         sin_cos(s.yaw_angle, sy, cy);
         sin_cos(s.gimbal_angle_a, sa, ca);
         sin_cos(s.gimbal_angle_b, sb, cb);
         g[0] = sb; g[1] = -qmul(sa, cb); g[2] = qmul(ca, cb);
         spsr = qmul(sp, sr); spcr = qmul(sp, cr);
         cpsr = qmul(cp, sr); cpcr = qmul(cp, cr);
         rm[0][0] = qmul(cy, cp);
         rm[0][1] = -qmul(sy, cr) + qmul(cy, spsr);
         rm[0][2] = qmul(sy, sr) + qmul(cy, spcr);
         rm[1][0] = qmul(sy, cp);
         rm[1][1] = qmul(cy, cr) + qmul(sy, spsr);
         rm[1][2] = -qmul(cy, sr) + qmul(sy, spcr);
         rm[2][0] = -sp; rm[2][1] = cpsr; rm[2][2] = cpcr;
         for (int i = 0; i < 3; i++) begin
            pm[i][0] = 0; pm[i][1] = rm[i][2]; pm[i][2] = -rm[i][1];
         end
         tm[0][0] = -qmul(cy, sp); tm[0][1] = qmul(cy, cpsr); tm[0][2] = qmul(cy, cpcr);
         tm[1][0] = -qmul(sy, sp); tm[1][1] = qmul(sy, cpsr); tm[1][2] = qmul(sy, cpcr);
         tm[2][0] = -cp; tm[2][1] = -spsr; tm[2][2] = -spcr;
         for (int i = 0; i < 3; i++) begin
            bm[i][0] = round_shift(pm[i][0] * g[0] + pm[i][1] * g[1] + pm[i][2] * g[2], 24);
            bm[i][1] = round_shift(tm[i][0] * g[0] + tm[i][1] * g[1] + tm[i][2] * g[2], 24);
            bm[i][2] = round_shift(rm[i][0] * g[0] + rm[i][1] * g[1] + rm[i][2] * g[2], 24);
         end
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
               cf[i][j] = round_shift(bm[(i+1)%3][(j+1)%3] * bm[(i+2)%3][(j+2)%3]
                                      - bm[(i+1)%3][(j+2)%3] * bm[(i+2)%3][(j+1)%3], 24);
         det = bm[0][0] * cf[0][0] + bm[0][1] * cf[0][1] + bm[0][2] * cf[0][2];
         if (kf == 0 || w == 0 || det == 0) begin
            o.command_x = clamp32(base[0]);
            o.command_y = clamp32(base[1]);
            o.command_z = clamp32(base[2]);
            o.singular_flag = 1'b1;
            return o;
         end
         for (int i = 0; i < 3; i++) begin
            y   = cf[0][i] * e[0] + cf[1][i] * e[1] + cf[2][i] * e[2];
            num = 128'(y < 0 ? -y : y) * 128'(mass);
            den = 128'(det < 0 ? -det : det) * 128'(kf);
            neg = (y < 0) != (det < 0);
            if (i < 2) begin
               num = num << 32;
               den = den * 128'(w < 0 ? -w : w);
               neg = neg != (w < 0);
            end else begin
               num = num << 24;
            end
            q = num / den;
            if (q > (128'd1 << 40)) q = 128'd1 << 40;
            corr = neg ? -longint'(q[63:0]) : longint'(q[63:0]);
            case (i)
               0: o.command_x = clamp32(base[0] + corr);
               1: o.command_y = clamp32(base[1] + corr);
               default: o.command_z = clamp32(base[2] + corr);
            endcase
         end
         o.singular_flag = 1'b0;
         return o;
      endfunction

      function void write_register(logic [1:0] idx, logic [31:0] val);
         if (idx == CSR_MASS) mass = val;
         else if (idx == CSR_KF) kf = val;
      endfunction

      function void note_sample(req_type s);
         awaited.push_back(command_law(s));
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            $error("unexpected result beat");
            failures++;
            return;
         end
         want = awaited.pop_front();
         if (got.command_x !== want.command_x) begin
            $error("command_x expected %0d got %0d", want.command_x, got.command_x);
            failures++;
         end
         if (got.command_y !== want.command_y) begin
            $error("command_y expected %0d got %0d", want.command_y, got.command_y);
            failures++;
         end
         if (got.command_z !== want.command_z) begin
            $error("command_z expected %0d got %0d", want.command_z, got.command_z);
            failures++;
         end
         if (got.singular_flag !== want.singular_flag) begin
            $error("singular_flag expected %0d got %0d", want.singular_flag, got.singular_flag);
            failures++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_strobe;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;

   command_scoreboard sb = new();
   int stall_cycles = 0;
   bit quiet = 0;

   indi_gimbal_control_law_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_result(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= 5000) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   task automatic send_sample(req_type s);
      if (!quiet && $urandom_range(0, 99) < 13) begin
         @(negedge clock);
         start = 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      @(negedge clock);
      start    = 1;
      req_data = s;
      do @(posedge clock); while (busy);
      sb.note_sample(s);
   endtask

   task automatic drain_pipeline();
      @(negedge clock);
      start = 0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (70) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_we    = 1;
      csr_index = idx;
      csr_wdata = val;
      @(posedge clock);
      sb.write_register(idx, val);
      @(negedge clock);
      csr_we = 0;
   endtask

   function automatic logic [31:0] pick_field(int width);
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0: v = 0;
         1: v = (32'd1 << (width - 1)) - 1;
         2: v = 32'd1 << (width - 1);
         3: v = 32'($signed($urandom_range(0, 32)) - 16);
         default: v = $urandom;
      endcase
      return v;
   endfunction

   function automatic req_type random_sample();
      req_type s;
      s.roll_angle     = 16'(pick_field(16));
      s.pitch_angle    = 16'(pick_field(16));
      s.yaw_angle      = 16'(pick_field(16));
      s.gimbal_angle_a = 16'(pick_field(16));
      s.gimbal_angle_b = 16'(pick_field(16));
      s.rotor_speed    = 24'(pick_field(24));
      s.error_x        = 24'(pick_field(24));
      s.error_y        = 24'(pick_field(24));
      s.error_z        = 24'(pick_field(24));
      return s;
   endfunction

   function automatic req_type make_sample(int r, int p, int y, int a, int b,
                                           int w, int ex, int ey, int ez);
      req_type s;
      s.roll_angle = 16'(r); s.pitch_angle = 16'(p); s.yaw_angle = 16'(y);
      s.gimbal_angle_a = 16'(a); s.gimbal_angle_b = 16'(b); s.rotor_speed = 24'(w);
      s.error_x = 24'(ex); s.error_y = 24'(ey); s.error_z = 24'(ez);
      return s;
   endfunction

   initial begin
      logic [31:0] mass_set[6];
      logic [31:0] kf_set[6];
      start = 0; req_data = '0; csr_we = 0; csr_index = CSR_MASS; csr_wdata = '0;
      reset = 1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;

      send_sample(make_sample(0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_sample(make_sample(0, 0, 0, 0, 0, 256, 65536, -65536, 32768));
      send_sample(make_sample(32767, 32767, 32767, 32767, 32767,
                              8388607, 8388607, 8388607, 8388607));
      send_sample(make_sample(-32768, -32768, -32768, -32768, -32768,
                              -8388608, -8388608, -8388608, -8388608));
      send_sample(make_sample(1000, 12868, -500, 0, 0, 512, 65536, 65536, 65536));
      send_sample(make_sample(1000, -12868, 300, 0, 0, 512, -65536, 65536, 65536));
      send_sample(make_sample(0, 0, 0, 12868, 0, 256, 65536, 65536, 65536));
      send_sample(make_sample(0, 0, 0, 0, 12868, 256, 65536, 65536, 65536));
      send_sample(make_sample(100, 200, 300, 400, 500, 1, 8388607, -8388608, 8388607));
      send_sample(make_sample(100, 200, 300, 400, 500, -1, -8388608, 8388607, 0));
      send_sample(make_sample(-2000, 1500, 25736, -800, 900, 4000, 0, 0, 0));
      send_sample(make_sample(25736, -25736, 0, 100, -100, -4000, 1234, -5678, 91011));
      drain_pipeline();

      mass_set = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'h0003_0000, 32'hFFFF_FFFF, 32'h0000_8000};
      kf_set   = '{32'd65536, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'h0002_0000};
      for (int ph = 0; ph < 6; ph++) begin
         write_csr(CSR_MASS, mass_set[ph]);
         write_csr(CSR_KF, kf_set[ph]);
         if (ph == 2) write_csr(2'd2, 32'hDEAD_BEEF);
         if (ph == 3) write_csr(2'd3, 32'd0);
         send_sample(make_sample(0, 0, 0, 0, 0, 1, 8388607, 8388607, -8388608));
         for (int n = 0; n < 20; n++) send_sample(random_sample());
         drain_pipeline();
      end

      write_csr(CSR_MASS, MASS_RESET);
      write_csr(CSR_KF, KF_RESET);
      for (int n = 0; n < 320; n++) begin
         quiet = (n >= 120 && n < 200);
         send_sample(random_sample());
      end
      drain_pipeline();

      if (sb.failures == 0 && sb.awaited.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/igcl_pkg.sv
rtl/igcl_div.sv
rtl/indi_gimbal_control_law_top.sv
sim/indi_gimbal_control_law_top_test.sv
